[hdl/assert_macros.svh]
// Assertion macros shared by the multi-value key table RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MVKT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define MVKT_NEVER(label, expr, msg) \
  `MVKT_ASSERT(label, !(expr), msg)

`endif

[hdl/mvkt_pkg.sv]
// Package for the multi-value key table: sizes, operation codes, types and
// field conversion functions. No dependencies.
package mvkt_pkg;

  localparam int CAPACITY   = 32;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam int OP_W      = 2;
  localparam int IN_KEY_W  = 32;
  localparam int IN_VAL_W  = 32;
  localparam int OUT_VAL_W = 32;
  localparam int RCNT_W    = 6;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef struct packed {
    logic en;
    idx_t addr;
    key_t key;
    val_t val;
  } store_wr_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } store_rd_t;

  // Input key, zero-extended or truncated to the stored key width.
  function automatic key_t to_key(input logic [IN_KEY_W-1:0] k);
    key_t r;
    for (int i = 0; i < KEY_BITS; i++) begin
      r[i] = (i < IN_KEY_W) ? k[(i < IN_KEY_W) ? i : 0] : 1'b0;
    end
    return r;
  endfunction

  // Input value, sign-extended or truncated to the stored value width.
  function automatic val_t to_val(input logic [IN_VAL_W-1:0] v);
    val_t r;
    for (int i = 0; i < VALUE_BITS; i++) begin
      r[i] = v[(i < IN_VAL_W) ? i : IN_VAL_W - 1];
    end
    return r;
  endfunction

  // Stored value, sign-extended or truncated to the result width.
  function automatic logic [OUT_VAL_W-1:0] to_out(input val_t v);
    logic [OUT_VAL_W-1:0] r;
    for (int i = 0; i < OUT_VAL_W; i++) begin
      r[i] = v[(i < VALUE_BITS) ? i : VALUE_BITS - 1];
    end
    return r;
  endfunction

endpackage

[hdl/mvkt_if.sv]
// Request and result channel interfaces of the multi-value key table.
// Depends on mvkt_pkg for field widths.
interface mvkt_in_if import mvkt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic [IN_KEY_W-1:0]        key;
  logic signed [IN_VAL_W-1:0] value;

  modport source (output valid, operation, key, value, input ready);
  modport sink   (input valid, operation, key, value, output ready);
endinterface

interface mvkt_out_if import mvkt_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_VAL_W-1:0] found_value;
  logic                        hit;
  logic [RCNT_W-1:0]           removed_count;
  logic                        status;
  logic                        last;

  modport source (output valid, found_value, hit, removed_count, status, last,
                  input ready);
  modport sink   (input valid, found_value, hit, removed_count, status, last,
                  output ready);
endinterface

[hdl/mvkt_store.sv]
// Key and value storage: one write port, one read port with registered data.
// Depends on mvkt_pkg.
module mvkt_store import mvkt_pkg::*; (
  input  logic      clk,
  input  store_wr_t wr,
  input  store_rd_t rd,
  output key_t      rd_key,
  output val_t      rd_val
);

  key_t key_mem [CAPACITY];
  val_t val_mem [CAPACITY];
  key_t rd_key_r;
  val_t rd_val_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr.addr] <= wr.key;
      val_mem[wr.addr] <= wr.val;
    end
    if (rd.en) begin
      rd_key_r <= key_mem[rd.addr];
      rd_val_r <= val_mem[rd.addr];
    end
  end

  assign rd_key = rd_key_r;
  assign rd_val = rd_val_r;

endmodule

[hdl/mvkt_ctrl.sv]
// Sequencer of the multi-value key table: writes inserts, scans the store one entry per
// cycle through a shared key compare (paused while a find result waits for the output),
// compacts on remove, drives results. Depends on mvkt_pkg, mvkt_if and assert_macros.svh.
`include "assert_macros.svh"

module mvkt_ctrl import mvkt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  mvkt_in_if.sink           in_req,
  mvkt_out_if.source        out_rsp,
  output store_wr_t         wr,
  output store_rd_t         rd,
  input  key_t              rd_key,
  input  val_t              rd_val
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINAL} state_t;

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  key_t                 key_r, key_nxt;
  cnt_t                 count_r, count_nxt;
  cnt_t                 rd_idx_r, rd_idx_nxt;
  cnt_t                 kept_r, kept_nxt;
  logic                 chk_v_r, chk_v_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [OUT_VAL_W-1:0] pend_val_r, pend_val_nxt;
  logic [OUT_VAL_W-1:0] fin_val_r, fin_val_nxt;
  logic                 fin_hit_r, fin_hit_nxt;
  logic [RCNT_W-1:0]    fin_rcnt_r, fin_rcnt_nxt;
  logic                 fin_status_r, fin_status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_VAL_W-1:0] out_value_r, out_value_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [RCNT_W-1:0]    out_rcnt_r, out_rcnt_nxt;
  logic                 out_status_r, out_status_nxt;
  logic                 out_last_r, out_last_nxt;

  logic accept, slot_free, match, chk_find, stall, issue, scan_done;
  logic emit_pend, emit_fin;

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign slot_free    = !out_valid_r || out_rsp.ready;
  assign match        = (rd_key == key_r);
  assign chk_find     = (state_r == S_SCAN) && chk_v_r && (op_r == OP_FIND) && match;
  assign stall        = chk_find && pend_v_r && !slot_free;
  assign issue        = (state_r == S_SCAN) && !stall && (rd_idx_r < count_r);
  assign scan_done    = (state_r == S_SCAN) && !chk_v_r && (rd_idx_r == count_r);
  assign emit_pend    = chk_find && pend_v_r && slot_free;
  assign emit_fin     = (state_r == S_FINAL) && slot_free;

  assign rd.en   = issue;
  assign rd.addr = rd_idx_r[IDX_W-1:0];

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = count_r[IDX_W-1:0];
    wr.key  = to_key(in_req.key);
    wr.val  = to_val(in_req.value);
    if (accept && (in_req.operation == OP_INSERT) && (count_r != cnt_t'(CAPACITY))) begin
      wr.en = 1'b1;
    end else if ((state_r == S_SCAN) && chk_v_r && (op_r == OP_REMOVE) && !match) begin
      wr.en   = 1'b1;
      wr.addr = kept_r[IDX_W-1:0];
      wr.key  = rd_key;
      wr.val  = rd_val;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    kept_nxt       = kept_r;
    chk_v_nxt      = chk_v_r;
    pend_v_nxt     = pend_v_r;
    pend_val_nxt   = pend_val_r;
    fin_val_nxt    = fin_val_r;
    fin_hit_nxt    = fin_hit_r;
    fin_rcnt_nxt   = fin_rcnt_r;
    fin_status_nxt = fin_status_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt         = op_t'(in_req.operation);
          key_nxt        = to_key(in_req.key);
          rd_idx_nxt     = '0;
          kept_nxt       = '0;
          chk_v_nxt      = 1'b0;
          pend_v_nxt     = 1'b0;
          fin_val_nxt    = '0;
          fin_hit_nxt    = 1'b0;
          fin_rcnt_nxt   = '0;
          fin_status_nxt = 1'b0;
          case (op_t'(in_req.operation))
            OP_INSERT: begin
              if (count_r == cnt_t'(CAPACITY)) begin
                fin_status_nxt = 1'b1;
              end else begin
                count_nxt = count_r + cnt_t'(1);
              end
              state_nxt = S_FINAL;
            end
            OP_FIND:   state_nxt = S_SCAN;
            OP_REMOVE: state_nxt = S_SCAN;
            default:   state_nxt = S_FINAL;
          endcase
        end
      end
      S_SCAN: begin
        if (chk_v_r && !stall) begin
          if (chk_find) begin
            pend_v_nxt   = 1'b1;
            pend_val_nxt = to_out(rd_val);
          end
          if ((op_r == OP_REMOVE) && !match) begin
            kept_nxt = kept_r + cnt_t'(1);
          end
        end
        chk_v_nxt = stall || issue;
        if (issue) begin
          rd_idx_nxt = rd_idx_r + cnt_t'(1);
        end
        if (scan_done) begin
          state_nxt = S_FINAL;
          if (op_r == OP_FIND) begin
            fin_val_nxt = pend_v_r ? pend_val_r : '0;
            fin_hit_nxt = pend_v_r;
          end else begin
            count_nxt    = kept_r;
            fin_hit_nxt  = (kept_r != count_r);
            fin_rcnt_nxt = RCNT_W'(count_r - kept_r);
          end
        end
      end
      S_FINAL: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_value_nxt  = out_value_r;
    out_hit_nxt    = out_hit_r;
    out_rcnt_nxt   = out_rcnt_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    if (emit_pend) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = pend_val_r;
      out_hit_nxt    = 1'b1;
      out_rcnt_nxt   = '0;
      out_status_nxt = 1'b0;
      out_last_nxt   = 1'b0;
    end else if (emit_fin) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = fin_val_r;
      out_hit_nxt    = fin_hit_r;
      out_rcnt_nxt   = fin_rcnt_r;
      out_status_nxt = fin_status_r;
      out_last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      kept_r      <= '0;
      chk_v_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      kept_r      <= kept_nxt;
      chk_v_r     <= chk_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    pend_val_r   <= pend_val_nxt;
    fin_val_r    <= fin_val_nxt;
    fin_hit_r    <= fin_hit_nxt;
    fin_rcnt_r   <= fin_rcnt_nxt;
    fin_status_r <= fin_status_nxt;
    out_value_r  <= out_value_nxt;
    out_hit_r    <= out_hit_nxt;
    out_rcnt_r   <= out_rcnt_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.found_value   = out_value_r;
  assign out_rsp.hit           = out_hit_r;
  assign out_rsp.removed_count = out_rcnt_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.last          = out_last_r;

  `MVKT_NEVER(a_count_bound, count_r > cnt_t'(CAPACITY), "entry count above capacity")
  `MVKT_ASSERT(a_scan_order, (state_r == S_SCAN) |-> (kept_r <= rd_idx_r) && (rd_idx_r <= count_r), "scan indexes out of order")
  `MVKT_ASSERT(a_emit_pend, emit_pend |=> pend_v_r && out_valid_r && !out_last_r, "non-final find result lost")
  `MVKT_NEVER(a_wr_ahead, wr.en && (state_r == S_SCAN) && (cnt_t'(wr.addr) >= rd_idx_r), "compaction write past scan")

endmodule

[hdl/multi_value_key_table_core.sv]
// Multi-value key table top level: a sequencer over a key/value store with one
// read port and one write port.
// Depends on mvkt_pkg, mvkt_if, mvkt_store and mvkt_ctrl.
//
// Holds up to CAPACITY key/value pairs in insertion order; keys may repeat.
// An insert answers with one result (status set when the table is full). A
// find or remove walks the stored entries one per cycle, while the output does
// not stall a find, through the store's single read port and one key compare;
// a find gives one result per matching value in stored order, the final one
// marked last, or a single result with hit clear. A remove closes the gaps
// during the same walk and answers with the number of pairs deleted. A new
// request is taken only once the previous one has handed its final result to
// the output register; output stalls during a find pause the walk.
module multi_value_key_table_core import mvkt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mvkt_in_if.sink    in_req,
  mvkt_out_if.source out_rsp
);

  store_wr_t wr;
  store_rd_t rd;
  key_t      rd_key;
  val_t      rd_val;

  mvkt_store u_store (
    .clk    (clk),
    .wr     (wr),
    .rd     (rd),
    .rd_key (rd_key),
    .rd_val (rd_val)
  );

  mvkt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .wr      (wr),
    .rd      (rd),
    .rd_key  (rd_key),
    .rd_val  (rd_val)
  );

endmodule

[sim/tb_top.sv]
// Self-checking testbench for multi_value_key_table_core: drives requests, predicts every
// result from a behavioral copy of the table and checks each one as it leaves the block.
// Depends on mvkt_pkg and the mvkt_in_if / mvkt_out_if channel interfaces.
module tb_top;
  import mvkt_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int TIMEOUT_CYCLES = 800000;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int KEY_POOL_N     = 6;
  localparam int REPORT_MAX     = 10;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [OUT_VAL_W-1:0] found_value;
    logic                        hit;
    logic [RCNT_W-1:0]           removed_count;
    logic                        status;
    logic                        last;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  mvkt_in_if  req_if ();
  mvkt_out_if rsp_if ();

  multi_value_key_table_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  key_t tbl_key [CAPACITY];
  val_t tbl_val [CAPACITY];
  int   tbl_count;

  rsp_t pending_results [$];
  logic [IN_KEY_W-1:0] key_pool [KEY_POOL_N];

  int  req_count;
  int  op_count [4];
  int  result_count;
  int  reject_count;
  int  max_removed;
  int  mismatch_count;
  bit  calm;
  int  hold_req;

  // Append one expected result to the tail of the queue.
  task automatic expect_rsp(input rsp_t r);
    pending_results = {pending_results, r};
  endtask

  // Table behavior: update the table copy and queue the results one request causes.
  task automatic apply_table_op(input logic [OP_W-1:0] op,
                                input logic [IN_KEY_W-1:0] key_in,
                                input logic signed [IN_VAL_W-1:0] val_in);
    key_t k;
    rsp_t r;
    int   total;
    int   seen;
    int   kept;
    k = key_t'(key_in);
    r = '0;
    r.last = 1'b1;
    case (op)
      OP_INSERT: begin
        if (tbl_count >= CAPACITY) begin
          r.status = 1'b1;
          reject_count++;
        end else begin
          tbl_key[tbl_count] = k;
          tbl_val[tbl_count] = val_t'(val_in);
          tbl_count++;
        end
        expect_rsp(r);
      end
      OP_FIND: begin
        total = 0;
        for (int i = 0; i < tbl_count; i++) if (tbl_key[i] == k) total++;
        if (total == 0) begin
          expect_rsp(r);
        end else begin
          seen = 0;
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_key[i] == k) begin
              seen++;
              r = '0;
              r.found_value = OUT_VAL_W'(signed'(tbl_val[i]));
              r.hit = 1'b1;
              r.last = (seen == total);
              expect_rsp(r);
            end
          end
        end
      end
      OP_REMOVE: begin
        kept = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_key[i] != k) begin
            tbl_key[kept] = tbl_key[i];
            tbl_val[kept] = tbl_val[i];
            kept++;
          end
        end
        r.removed_count = RCNT_W'(tbl_count - kept);
        r.hit = (tbl_count != kept);
        if (tbl_count - kept > max_removed) max_removed = tbl_count - kept;
        tbl_count = kept;
        expect_rsp(r);
      end
      default: expect_rsp(r);
    endcase
  endtask

  // Offer one request, with an occasional idle burst ahead of it, and predict on acceptance.
  task automatic send_req(input logic [OP_W-1:0] op, input logic [IN_KEY_W-1:0] key,
                          input logic signed [IN_VAL_W-1:0] value);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid     = 1'b1;
    req_if.operation = op;
    req_if.key       = key;
    req_if.value     = value;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    apply_table_op(op, key, value);
    req_count++;
    op_count[op]++;
  endtask

  always @(posedge clk) begin : check_results
    rsp_t got;
    rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.found_value   = rsp_if.found_value;
      got.hit           = rsp_if.hit;
      got.removed_count = rsp_if.removed_count;
      got.status        = rsp_if.status;
      got.last          = rsp_if.last;
      result_count++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("result %0d arrived with none expected: value %0d hit %0b removed %0d status %0b last %0b",
                   result_count, got.found_value, got.hit, got.removed_count, got.status,
                   got.last);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("result %0d mismatch: expected value %0d hit %0b removed %0d status %0b last %0b",
                     result_count, want.found_value, want.hit, want.removed_count, want.status,
                     want.last);
            $display("                     actual value %0d hit %0b removed %0d status %0b last %0b",
                     got.found_value, got.hit, got.removed_count, got.status, got.last);
          end
        end
      end
    end
  end

  // Result side: random stall bursts, plus a long hold-off on request.
  initial begin : drive_ready
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_if.ready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  task automatic test_directed;
    send_req(OP_FIND,   32'h0000_0000, 32'sd0);
    send_req(OP_REMOVE, 32'h0000_0000, 32'sd0);
    send_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_INSERT, 32'h0000_0000, 32'h8000_0000);
    send_req(OP_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_req(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_req(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_INSERT, 32'hA5A5_5A5A, 32'h0000_0001);
    send_req(OP_FIND,   32'h0000_0000, 32'h1234_5678);
    send_req(OP_FIND,   32'hFFFF_FFFF, 32'sd0);
    send_req(OP_FIND,   32'h0000_0001, 32'sd0);
    send_req(OP_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_req(OP_FIND,   32'h0000_0000, 32'sd0);
    send_req(OP_FIND,   32'hFFFF_FFFF, 32'sd0);
    send_req(OP_UNUSED, 32'hA5A5_5A5A, 32'h0000_0001);
    send_req(OP_FIND,   32'hA5A5_5A5A, 32'sd0);
    send_req(OP_REMOVE, 32'hFFFF_FFFF, 32'sd0);
    send_req(OP_REMOVE, 32'hA5A5_5A5A, 32'sd0);
    send_req(OP_FIND,   32'hA5A5_5A5A, 32'sd0);
  endtask

  // Fill with one key, overflow, read all back, then delete the whole table at once.
  task automatic test_fill_and_drain;
    while (tbl_count < CAPACITY) send_req(OP_INSERT, key_pool[2], $urandom);
    send_req(OP_INSERT, key_pool[3], $urandom);
    send_req(OP_INSERT, key_pool[2], $urandom);
    send_req(OP_FIND,   key_pool[2], $urandom);
    send_req(OP_FIND,   key_pool[3], $urandom);
    send_req(OP_REMOVE, key_pool[2], $urandom);
    send_req(OP_FIND,   key_pool[2], $urandom);
  endtask

  task automatic test_backpressure;
    @(posedge clk);
    hold_req = 300;
    for (int i = 0; i < 6; i++) send_req(OP_INSERT, key_pool[i % 2], $urandom);
    send_req(OP_FIND, key_pool[0], $urandom);
    send_req(OP_FIND, key_pool[1], $urandom);
    send_req(OP_REMOVE, key_pool[0], $urandom);
    send_req(OP_FIND, key_pool[1], $urandom);
  endtask

  task automatic test_random_mix(input int n_items);
    int pick;
    int ins_pct;
    logic [OP_W-1:0] op;
    logic [IN_KEY_W-1:0] key;
    for (int i = 0; i < n_items; i++) begin
      ins_pct = (i % 80 < 40) ? 70 : 35;
      pick = $urandom_range(0, 99);
      if (pick < ins_pct) op = OP_INSERT;
      else if (pick < ins_pct + (100 - ins_pct) * 55 / 100) op = OP_FIND;
      else if (pick < 96) op = OP_REMOVE;
      else op = OP_UNUSED;
      if ($urandom_range(0, 9) == 0) key = $urandom;
      else key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
      send_req(op, key, $urandom);
    end
  endtask

  task automatic test_steady_tail;
    calm = 1'b1;
    test_random_mix(20);
  endtask

  initial begin : main_sequence
    int waited;
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.operation = '0;
    req_if.key = '0;
    req_if.value = '0;
    tbl_count = 0;
    calm = 1'b0;
    hold_req = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_fill_and_drain();
    test_backpressure();
    test_random_mix(245);
    test_steady_tail();

    @(negedge clk);
    req_if.valid = 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * CAPACITY + 16) @(posedge clk);

    $display("Covered %0d requests: %0d inserts (%0d refused on a full table), %0d finds, %0d removes, %0d unused codes.",
             req_count, op_count[OP_INSERT], reject_count, op_count[OP_FIND],
             op_count[OP_REMOVE], op_count[OP_UNUSED]);
    $display("Checked %0d results, largest single removal %0d pairs, %0d mismatches, %0d results never seen.",
             result_count, max_removed, mismatch_count, pending_results.size());
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("Run exceeded %0d cycles.", TIMEOUT_CYCLES);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/mvkt_pkg.sv
hdl/mvkt_if.sv
hdl/mvkt_store.sv
hdl/mvkt_ctrl.sv
hdl/multi_value_key_table_core.sv
sim/tb_top.sv
